>>> rtl/core/configurable_gf256_sbox_core_assert.svh
// Assertion macros shared by the sbox core RTL.
`ifndef CONFIGURABLE_GF256_SBOX_CORE_ASSERT_SVH
`define CONFIGURABLE_GF256_SBOX_CORE_ASSERT_SVH

// ante holds now, cons holds on the next clock
`define CGS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sbox core assertion failed");

// ante holds now, cons holds dly clocks later
`define CGS_ASSERT_DLY(lbl, ante, dly, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error("sbox core assertion failed");

`endif

>>> rtl/core/cgs_pkg.sv
// ----------------------------------------------------------------------------
// cgs_pkg
// Types, register map and GF(2^8) helpers for the configurable sbox core.
// ----------------------------------------------------------------------------
package cgs_pkg;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_FIELD_POLY   = 2'd0;
	localparam logic [1:0] REG_AFFINE_MASK  = 2'd1;
	localparam logic [1:0] REG_AFFINE_CONST = 2'd2;

	localparam logic [8:0] FIELD_POLY_RST   = 9'h11B;
	localparam logic [7:0] AFFINE_MASK_RST  = 8'h1F;
	localparam logic [7:0] AFFINE_CONST_RST = 8'h15;

	typedef struct packed {
		logic [8:0] field_poly;
		logic [7:0] affine_mask;
		logic [7:0] affine_const;
	} cfg_t;

	// multiply by x, x^8 term implied
	function automatic logic [7:0] gf_xtime(input logic [7:0] a, input logic [7:0] p);
		return {a[6:0], 1'b0} ^ (a[7] ? p : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] p);
		logic [7:0] acc;
		logic [7:0] sh;
		acc = 8'h00;
		sh  = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ sh;
			end
			sh = gf_xtime(sh, p);
		end
		return acc;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] v, input int unsigned j);
		logic [15:0] tmp;
		tmp = {v, v};
		tmp = tmp << j;
		return tmp[15:8];
	endfunction

	function automatic logic [7:0] affine_map(input logic [7:0] v, input logic [7:0] mask,
		input logic [7:0] cst);
		logic [7:0] acc;
		acc = 8'h00;
		for (int j = 0; j < 8; j++) begin
			if (mask[j]) begin
				acc = acc ^ rotl8(v, j);
			end
		end
		return acc ^ cst;
	endfunction

endpackage

>>> rtl/core/configurable_gf256_sbox_core.sv
// ----------------------------------------------------------------------------
// configurable_gf256_sbox_core
// AES-style byte substitution: GF(2^8) inverse under a programmable
// polynomial, then a programmable circulant affine map.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive byte_in and pulse start; an item is taken at every edge with
//   start high and busy low. busy is always low, so one item per cycle.
//   Output: valid is high for one cycle with byte_out; the receiver must take
//   it then, since it cannot hold results off.
//   Path: an item taken at an edge passes exponent stages s1 to s10 and
//   the affine output register s11 before it shows on valid/byte_out.
//   Throughput: one item per cycle, set by the ten-stage exponent pipeline
//   (one field multiply per stage, two in s5) plus the affine output stage.
//   Config: APB registers field_poly (0x0), affine_mask (0x4),
//   affine_const (0x8); write only while no item is in flight.
//   Reset: arst_n clears all stage valids and loads the standard AES
//   polynomial 0x11B, mask 0x1F and constant 0x15.
// ----------------------------------------------------------------------------
`include "configurable_gf256_sbox_core_assert.svh"

module configurable_gf256_sbox_core
	import cgs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [7:0]        byte_in,
	output logic              valid,
	output logic [7:0]        byte_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t       cfg;
	logic       inv_valid;
	logic [7:0] inv_byte;

	assign busy = 1'b0;

	cgs_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cgs_inv_pipe u_inv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.in_byte   (byte_in),
		.poly      (cfg.field_poly[7:0]),
		.out_valid (inv_valid),
		.out_inv   (inv_byte)
	);

	cgs_affine u_aff (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (inv_valid),
		.in_inv    (inv_byte),
		.cfg       (cfg),
		.out_valid (valid),
		.out_byte  (byte_out)
	);

	`CGS_ASSERT_DLY(a_item_out, start && !busy, 11, valid)
	`CGS_ASSERT_DLY(a_no_item_out, !start, 11, !valid)

endmodule

>>> rtl/core/cgs_cfg_regs.sv
// ----------------------------------------------------------------------------
// cgs_cfg_regs
// APB-style register file: field polynomial, affine mask, affine constant.
// ----------------------------------------------------------------------------
module cgs_cfg_regs
	import cgs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [8:0] field_poly_q;
	logic [7:0] affine_mask_q;
	logic [7:0] affine_const_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_poly_q   <= FIELD_POLY_RST;
			affine_mask_q  <= AFFINE_MASK_RST;
			affine_const_q <= AFFINE_CONST_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FIELD_POLY:   field_poly_q   <= pwdata[8:0];
				REG_AFFINE_MASK:  affine_mask_q  <= pwdata[7:0];
				REG_AFFINE_CONST: affine_const_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FIELD_POLY:   prdata = {23'd0, field_poly_q};
			REG_AFFINE_MASK:  prdata = {24'd0, affine_mask_q};
			REG_AFFINE_CONST: prdata = {24'd0, affine_const_q};
			default:          prdata = '0;
		endcase
	end

	assign cfg.field_poly   = field_poly_q;
	assign cfg.affine_mask  = affine_mask_q;
	assign cfg.affine_const = affine_const_q;

endmodule

>>> rtl/core/cgs_inv_pipe.sv
// ----------------------------------------------------------------------------
// cgs_inv_pipe
// Ten-stage a^254 pipeline, one field multiply per stage (two in stage 5).
// Chain: a2, a3, a6, a12, {a14,a15}, a30, a60, a120, a240, a240*a14.
// ----------------------------------------------------------------------------
`include "configurable_gf256_sbox_core_assert.svh"

module cgs_inv_pipe
	import cgs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	input  logic [7:0] poly,
	output logic       out_valid,
	output logic [7:0] out_inv
);

	logic       vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic       vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic [7:0] a_s1, a2_s1;
	logic [7:0] a2_s2, a3_s2;
	logic [7:0] a2_s3, a3_s3, a6_s3;
	logic [7:0] a2_s4, a3_s4, a12_s4;
	logic [7:0] a14_s5, a15_s5;
	logic [7:0] a14_s6, a30_s6;
	logic [7:0] a14_s7, a60_s7;
	logic [7:0] a14_s8, a120_s8;
	logic [7:0] a14_s9, a240_s9;
	logic [7:0] inv_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= in_byte;
		a2_s1   <= gf_mul(in_byte, in_byte, poly);
		a2_s2   <= a2_s1;
		a3_s2   <= gf_mul(a2_s1, a_s1, poly);
		a2_s3   <= a2_s2;
		a3_s3   <= a3_s2;
		a6_s3   <= gf_mul(a3_s2, a3_s2, poly);
		a2_s4   <= a2_s3;
		a3_s4   <= a3_s3;
		a12_s4  <= gf_mul(a6_s3, a6_s3, poly);
		a14_s5  <= gf_mul(a12_s4, a2_s4, poly);
		a15_s5  <= gf_mul(a12_s4, a3_s4, poly);
		a14_s6  <= a14_s5;
		a30_s6  <= gf_mul(a15_s5, a15_s5, poly);
		a14_s7  <= a14_s6;
		a60_s7  <= gf_mul(a30_s6, a30_s6, poly);
		a14_s8  <= a14_s7;
		a120_s8 <= gf_mul(a60_s7, a60_s7, poly);
		a14_s9  <= a14_s8;
		a240_s9 <= gf_mul(a120_s8, a120_s8, poly);
		inv_s10 <= gf_mul(a240_s9, a14_s9, poly);
	end

	assign out_valid = vld_s10;
	assign out_inv   = inv_s10;

	// zero and one are fixed points of the inversion for any polynomial
	`CGS_ASSERT_DLY(a_zero_inv, vld_s1 && (a_s1 == 8'h00), 9, vld_s10 && (inv_s10 == 8'h00))
	`CGS_ASSERT_DLY(a_one_inv, vld_s1 && (a_s1 == 8'h01), 9, vld_s10 && (inv_s10 == 8'h01))

endmodule

>>> rtl/core/cgs_affine.sv
// ----------------------------------------------------------------------------
// cgs_affine
// Circulant affine map and output register.
// ----------------------------------------------------------------------------
`include "configurable_gf256_sbox_core_assert.svh"

module cgs_affine
	import cgs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_inv,
	input  cfg_t       cfg,
	output logic       out_valid,
	output logic [7:0] out_byte
);

	logic       vld_s11;
	logic [7:0] byte_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else begin
			vld_s11 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		byte_s11 <= affine_map(in_inv, cfg.affine_mask, cfg.affine_const);
	end

	assign out_valid = vld_s11;
	assign out_byte  = byte_s11;

	// empty mask leaves only the constant
	`CGS_ASSERT_NXT(a_mask_zero, in_valid && (cfg.affine_mask == 8'h00), out_byte == cfg.affine_const)
	`CGS_ASSERT_NXT(a_inv_zero, in_valid && (in_inv == 8'h00), out_byte == cfg.affine_const)

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the configurable GF(2^8) sbox core. A local
// predictor works out each substituted byte from the register settings it
// tracks. The predictor is an inverse by power 254 over the programmed
// polynomial, followed by the circulant affine map. A queued driver feeds
// bytes with random idle bursts. A monitor checks every strobed result
// against the oldest prediction. Registers are rewritten over APB between
// phases once the pipe has drained.
// ----------------------------------------------------------------------------
module testbench;
	import cgs_pkg::*;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              start   = 1'b0;
	logic              busy;
	logic [7:0]        byte_in = 8'h00;
	logic              valid;
	logic [7:0]        byte_out;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [DATA_W-1:0] pwdata  = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// register copies used by the predictor
	logic [8:0] poly_cfg  = FIELD_POLY_RST;
	logic [7:0] mask_cfg  = AFFINE_MASK_RST;
	logic [7:0] const_cfg = AFFINE_CONST_RST;

	logic [7:0] byte_pending_q[$];
	logic [7:0] sbox_expect_q[$];

	int idle_odds     = 0;  // one in idle_odds cycles starts a gap; 0 means no gaps
	int idle_left     = 0;
	int items_taken   = 0;
	int bytes_checked = 0;
	int mismatches    = 0;
	int unexpected    = 0;
	int settings_used = 1;

	configurable_gf256_sbox_core dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .byte_in(byte_in),
		.valid(valid), .byte_out(byte_out),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	// carry-less product, then long division by x^8 + poly[7:0]
	function automatic logic [7:0] field_product(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] poly_low);
		logic [14:0] prod;
		logic [14:0] modulus;
		prod = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				prod = prod ^ (15'(a) << i);
			end
		end
		modulus = {6'b0, 1'b1, poly_low};
		for (int k = 14; k >= 8; k--) begin
			if (prod[k]) begin
				prod = prod ^ (modulus << (k - 8));
			end
		end
		return prod[7:0];
	endfunction

	// a^254 = a^2 * a^4 * ... * a^128; zero stays zero
	function automatic logic [7:0] field_inverse(input logic [7:0] a, input logic [7:0] poly_low);
		logic [7:0] pow2;
		logic [7:0] acc;
		pow2 = a;
		acc  = 8'h01;
		for (int k = 1; k < 8; k++) begin
			pow2 = field_product(pow2, pow2, poly_low);
			acc  = field_product(acc, pow2, poly_low);
		end
		return acc;
	endfunction

	function automatic logic [7:0] sbox_predict(input logic [7:0] b, input logic [8:0] poly,
		input logic [7:0] mask, input logic [7:0] cst);
		logic [7:0] rot;
		logic [7:0] acc;
		rot = field_inverse(b, poly[7:0]);
		acc = cst;
		for (int j = 0; j < 8; j++) begin
			if (mask[j]) begin
				acc = acc ^ rot;
			end
			rot = {rot[6:0], rot[7]};
		end
		return acc;
	endfunction

	// driver: one item per accepted edge, with random idle bursts between items
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			idle_left = 0;
		end else begin
			if (start && !busy) begin
				sbox_expect_q.push_back(sbox_predict(byte_in, poly_cfg, mask_cfg, const_cfg));
				items_taken++;
			end
			if (start && busy) begin
				// item not taken yet, keep it on the port
			end else if (idle_left > 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (byte_pending_q.size() != 0 && idle_odds != 0 &&
				$urandom_range(idle_odds - 1, 0) == 0) begin
				idle_left = $urandom_range(17, 0);
				start <= 1'b0;
			end else if (byte_pending_q.size() != 0) begin
				byte_in <= byte_pending_q.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: results cannot be held off, so every strobe is checked
	always @(posedge clk) begin
		if (arst_n && valid) begin
			if (sbox_expect_q.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10) begin
					$display("unexpected result byte_out=%02h", byte_out);
				end
			end else begin
				logic [7:0] want;
				want = sbox_expect_q.pop_front();
				bytes_checked++;
				if (byte_out !== want) begin
					mismatches++;
					if (mismatches + unexpected <= 10) begin
						$display("mismatch byte_out: expected %02h, got %02h", want, byte_out);
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		case (idx)
			REG_FIELD_POLY:   poly_cfg  = data[8:0];
			REG_AFFINE_MASK:  mask_cfg  = data[7:0];
			REG_AFFINE_CONST: const_cfg = data[7:0];
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic wait_drained();
		while (byte_pending_q.size() != 0 || start || sbox_expect_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// program the registers, then send n random bytes; optionally hold off
	// halfway until every result of the first half is back
	task automatic run_phase(input logic [8:0] poly, input logic [7:0] mask,
		input logic [7:0] cst, input int odds, input int n, input bit pause_mid);
		logic [DATA_W-1:0] junk;
		wait_drained();
		junk = $urandom_range(1, 0) ? $urandom : 32'h0;
		write_reg(REG_FIELD_POLY, {junk[31:9], poly});
		junk = $urandom_range(1, 0) ? $urandom : 32'h0;
		write_reg(REG_AFFINE_MASK, {junk[31:8], mask});
		write_reg(REG_AFFINE_CONST, {24'h0, cst});
		settings_used++;
		@(negedge clk);
		idle_odds = odds;
		for (int i = 0; i < n; i++) begin
			if (pause_mid && i == n / 2) begin
				wait_drained();
			end
			byte_pending_q.push_back(8'($urandom));
		end
	endtask

	logic [8:0] poly_dir[6]  = '{9'h11B, 9'h100, 9'h1FF, 9'h01B, 9'h11D, 9'h000};
	logic [7:0] mask_dir[6]  = '{8'h00, 8'hFF, 8'h01, 8'h1F, 8'h80, 8'h03};
	logic [7:0] const_dir[6] = '{8'h00, 8'hFF, 8'hAA, 8'h63, 8'h00, 8'h5A};
	logic [7:0] edge_bytes[16] = '{8'h00, 8'h01, 8'hFF, 8'h80, 8'h7F, 8'h02, 8'h03, 8'h53,
		8'hCA, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h10, 8'hFE, 8'h8D};

	initial begin
		logic [8:0] poly;
		int odds;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: field edge values and the zero byte
		idle_odds = 4;
		foreach (edge_bytes[i]) begin
			byte_pending_q.push_back(edge_bytes[i]);
		end

		// zero, full and single-bit masks, reducible and x^8-less polynomials
		for (int p = 0; p < 6; p++) begin
			run_phase(poly_dir[p], mask_dir[p], const_dir[p], (p % 3 == 2) ? 0 : 2 + 3 * p,
				100, p == 1);
		end

		for (int p = 0; p < 8; p++) begin
			poly = ($urandom_range(3, 0) != 0) ? 9'($urandom_range(511, 256))
				: 9'($urandom_range(511, 0));
			odds = (p % 4 == 3 || p == 7) ? 0 : $urandom_range(12, 2);
			run_phase(poly, 8'($urandom), 8'($urandom), odds, 100, p == 4);
		end

		wait_drained();
		repeat (20) @(negedge clk);

		$display("Run covered %0d items under %0d register settings; %0d results checked.",
			items_taken, settings_used, bytes_checked);
		$display("Settings included reducible, x^8-less, zero-mask and even-mask cases.");
		if (mismatches == 0 && unexpected == 0 && sbox_expect_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d unexpected results, %0d missing", mismatches,
				unexpected, sbox_expect_q.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#4800000;
		$display("timeout with %0d results outstanding", sbox_expect_q.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
